@@ rtl/core/rdp_pkg.sv @@
// Shared types and constants for the polyline simplifier.
// No dependencies; imported by rdp_mul and polyline_simplify_rdp.
`timescale 1ns / 1ps

package rdp_pkg;

   // Limb width of the shared multiplier.
   localparam int LIMB_W = 16;

   // Tolerance register.
   localparam int TOL_W = 23;
   localparam logic [TOL_W-1:0] TOL_RESET = 23'd256;

   typedef enum logic [25:0] {
      S_LOAD     = 26'h0000001,
      S_TOL      = 26'h0000002,
      S_POP      = 26'h0000004,
      S_SEGRD    = 26'h0000008,
      S_RDF      = 26'h0000010,
      S_RDL      = 26'h0000020,
      S_LEN_A    = 26'h0000040,
      S_LEN_B    = 26'h0000080,
      S_THR      = 26'h0000100,
      S_PTRD     = 26'h0000200,
      S_PT       = 26'h0000400,
      S_DOT_A    = 26'h0000800,
      S_DOT_B    = 26'h0001000,
      S_BR       = 26'h0002000,
      S_SQ_A     = 26'h0004000,
      S_SQ_B     = 26'h0008000,
      S_SCALE    = 26'h0010000,
      S_CR_A     = 26'h0020000,
      S_CR_B     = 26'h0040000,
      S_CR_SQ    = 26'h0080000,
      S_CMP      = 26'h0100000,
      S_DEC      = 26'h0200000,
      S_PUSH2    = 26'h0400000,
      S_OUT_SCAN = 26'h0800000,
      S_OUT_RD   = 26'h1000000,
      S_OUT_WAIT = 26'h2000000
   } state_type;

endpackage

@@ rtl/core/rdp_mul.sv @@
// Iterative unsigned multiplier, one 16x16 partial product per cycle.
// Depends on rdp_pkg for the limb width.
`timescale 1ns / 1ps

module rdp_mul #(
   parameter int MW = 51
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [MW-1:0] a,
   input  logic [MW-1:0] b,
   output logic          done,
   output logic [2*MW-1:0] p
);
   import rdp_pkg::*;

   localparam int NL   = (MW + LIMB_W - 1) / LIMB_W;
   localparam int PADW = NL * LIMB_W;
   localparam int PW   = 2 * MW;
   localparam int KW   = (NL > 1) ? $clog2(NL) : 1;

   logic [PADW-1:0]     a_ff, b_ff;
   logic [KW-1:0]       i_ff, i_in, j_ff, j_in;
   logic [PW-1:0]       acc_ff, acc_in;
   logic                busy_ff, busy_in, done_ff, done_in;
   logic [2*LIMB_W-1:0] pp;
   logic                last_step;

   assign pp = a_ff[i_ff*LIMB_W +: LIMB_W] * b_ff[j_ff*LIMB_W +: LIMB_W];
   assign last_step = (i_ff == KW'(NL-1)) && (j_ff == KW'(NL-1));

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      i_in    = i_ff;
      j_in    = j_ff;
      acc_in  = acc_ff;
      if (start) begin
         busy_in = 1'b1;
         i_in    = '0;
         j_in    = '0;
         acc_in  = '0;
      end else if (busy_ff) begin
         acc_in = acc_ff + (PW'(pp) << ((int'(i_ff) + int'(j_ff)) * LIMB_W));
         if (last_step) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else if (j_ff == KW'(NL-1)) begin
            j_in = '0;
            i_in = i_ff + 1'b1;
         end else begin
            j_in = j_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         i_ff    <= '0;
         j_ff    <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         i_ff    <= i_in;
         j_ff    <= j_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      if (start) begin
         a_ff <= PADW'(a);
         b_ff <= PADW'(b);
      end
   end

   assign done = done_ff;
   assign p    = acc_ff;

endmodule

@@ rtl/core/polyline_simplify_rdp.sv @@
// Ramer-Douglas-Peucker polyline simplifier in the XZ plane.
// Depends on rdp_pkg and rdp_mul.
//
// Usage: points arrive on the req_ channel, one beat per point, with
// req_in_last on the final point. A polyline is also closed when it fills
// MAX_POINTS entries. Loading accepts one point per cycle. After the final
// point req_ready drops while the line is simplified with a segment stack;
// all arithmetic runs through one shared limb multiplier that works on NL
// 16-bit limbs per operand, NL being the limb count of the widest operand
// (4 at the default width). Each interior point of a segment costs five
// products, and each segment adds three products for the chord length and
// threshold. The kept points then leave on the rsp_ channel in input order,
// rsp_out_last on the final one. A stalled receiver simply holds the state machine.
// Once the last beat is taken req_ready rises.
// The user must write the tolerance on the csr_ channel only while the block is idle;
// the block itself does not enforce this.
// Reset returns the tolerance to 256 and empties the point buffer.
`timescale 1ns / 1ps

module polyline_simplify_rdp #(
   parameter int MAX_POINTS  = 64,
   parameter int COORD_WIDTH = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [COORD_WIDTH-1:0] req_in_x,
   input  logic signed [COORD_WIDTH-1:0] req_in_y,
   input  logic signed [COORD_WIDTH-1:0] req_in_z,
   input  logic                          req_in_last,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [COORD_WIDTH-1:0] rsp_out_x,
   output logic signed [COORD_WIDTH-1:0] rsp_out_y,
   output logic signed [COORD_WIDTH-1:0] rsp_out_z,
   output logic                          rsp_out_last,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [rdp_pkg::TOL_W-1:0]     csr_tolerance
);
   import rdp_pkg::*;

   localparam int CW   = COORD_WIDTH;
   localparam int IW   = $clog2(MAX_POINTS);
   localparam int CNTW = IW + 1;
   localparam int DW   = CW + 1;
   localparam int LW   = 2 * CW + 3;
   localparam int ACCW = LW + 1;
   localparam int MW   = (LW > 2 * TOL_W) ? LW : 2 * TOL_W;
   localparam int PW   = 2 * MW;

   function automatic logic signed [DW-1:0] sdiff(input logic signed [CW-1:0] a,
                                                  input logic signed [CW-1:0] b);
      return $signed({a[CW-1], a}) - $signed({b[CW-1], b});
   endfunction

   function automatic logic [DW-1:0] mag_d(input logic signed [DW-1:0] v);
      return v[DW-1] ? unsigned'(-v) : unsigned'(v);
   endfunction

   state_type state_ff, state_in;

   logic [3*CW-1:0] pt_mem [MAX_POINTS];
   logic [3*CW-1:0] rd_data_ff;
   logic [IW-1:0]   rd_addr;
   logic [2*IW-1:0] stk_mem [MAX_POINTS];
   logic [2*IW-1:0] stk_rd_ff, stk_wd;
   logic [IW-1:0]   stk_ra, stk_wa;
   logic            stk_we;

   logic [TOL_W-1:0]       tol_ff;
   logic [MW-1:0]          tol2_ff, tol2_in;
   logic [CNTW-1:0]        cnt_ff, cnt_in, top_ff, top_in;
   logic [MAX_POINTS-1:0]  kf_ff, kf_in;
   logic [IW-1:0]          f_ff, f_in, l_ff, l_in, i_ff, i_in, j_ff, j_in;
   logic [IW-1:0]          best_at_ff, best_at_in, nl;
   logic                   run_ff, run_in, first_ff, first_in;
   logic signed [CW-1:0]   xf_ff, xf_in, zf_ff, zf_in, xl_ff, xl_in, zl_ff, zl_in;
   logic signed [CW-1:0]   xi_ff, xi_in, zi_ff, zi_in;
   logic signed [DW-1:0]   u_ff, u_in, v_ff, v_in;
   logic signed [ACCW-1:0] acc_ff, acc_in, prod_s, term, acc_sum;
   logic [LW-1:0]          len2_ff, len2_in;
   logic [PW-1:0]          thr_ff, thr_in, score_ff, score_in, best_ff, best_in;
   logic                   rsp_valid_ff, rsp_valid_in, out_last_ff, out_last_in;
   logic [3*CW-1:0]        out_ff, out_in;

   logic signed [DW-1:0] dx, dz, ex, ez, abx, abz;
   logic [ACCW-1:0]      acc_mag;
   logic [MW-1:0]        factor, op_a, op_b;
   logic                 neg, mul_start, mul_done;
   logic [PW-1:0]        mul_p;
   logic signed [CW-1:0] rdx, rdz;
   logic                 req_fire;

   rdp_mul #(.MW(MW)) u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (op_a),
      .b     (op_b),
      .done  (mul_done),
      .p     (mul_p)
   );

   assign rdx = rd_data_ff[3*CW-1:2*CW];
   assign rdz = rd_data_ff[CW-1:0];
   assign dx  = sdiff(xi_ff, xf_ff);
   assign dz  = sdiff(zi_ff, zf_ff);
   assign ex  = sdiff(xi_ff, xl_ff);
   assign ez  = sdiff(zi_ff, zl_ff);
   assign abx = sdiff(xl_ff, xf_ff);
   assign abz = sdiff(zl_ff, zf_ff);
   assign nl  = IW'(cnt_ff - 1'b1);

   assign acc_mag = acc_ff[ACCW-1] ? unsigned'(-acc_ff) : unsigned'(acc_ff);
   // A degenerate chord scales by one, which measures plain squared distance to the first point.
   assign factor  = (len2_ff == '0) ? MW'(1) : MW'(len2_ff);
   assign prod_s  = $signed(mul_p[ACCW-1:0]);
   assign term    = neg ? -prod_s : prod_s;
   assign acc_sum = acc_ff + term;

   assign req_ready = (state_ff == S_LOAD);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign stk_ra    = IW'(top_ff - 1'b1);

   // Operands of the shared multiplier and the sign of the product.
   always_comb begin
      op_a = '0;
      op_b = '0;
      neg  = 1'b0;
      case (state_ff)
         S_TOL: begin
            op_a = MW'(tol_ff);
            op_b = MW'(tol_ff);
         end
         S_LEN_A: begin
            op_a = MW'(mag_d(abx));
            op_b = MW'(mag_d(abx));
         end
         S_LEN_B: begin
            op_a = MW'(mag_d(abz));
            op_b = MW'(mag_d(abz));
         end
         S_THR: begin
            op_a = tol2_ff;
            op_b = factor;
         end
         S_DOT_A: begin
            op_a = MW'(mag_d(dx));
            op_b = MW'(mag_d(abx));
            neg  = dx[DW-1] ^ abx[DW-1];
         end
         S_DOT_B: begin
            op_a = MW'(mag_d(dz));
            op_b = MW'(mag_d(abz));
            neg  = dz[DW-1] ^ abz[DW-1];
         end
         S_SQ_A: begin
            op_a = MW'(mag_d(u_ff));
            op_b = MW'(mag_d(u_ff));
         end
         S_SQ_B: begin
            op_a = MW'(mag_d(v_ff));
            op_b = MW'(mag_d(v_ff));
         end
         S_SCALE: begin
            op_a = MW'(acc_mag);
            op_b = factor;
         end
         S_CR_A: begin
            op_a = MW'(mag_d(dx));
            op_b = MW'(mag_d(abz));
            neg  = dx[DW-1] ^ abz[DW-1];
         end
         S_CR_B: begin
            op_a = MW'(mag_d(dz));
            op_b = MW'(mag_d(abx));
            neg  = !(dz[DW-1] ^ abx[DW-1]);
         end
         S_CR_SQ: begin
            op_a = MW'(acc_mag);
            op_b = MW'(acc_mag);
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      tol2_in      = tol2_ff;
      cnt_in       = cnt_ff;
      top_in       = top_ff;
      kf_in        = kf_ff;
      f_in         = f_ff;
      l_in         = l_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      best_at_in   = best_at_ff;
      first_in     = first_ff;
      xf_in        = xf_ff;
      zf_in        = zf_ff;
      xl_in        = xl_ff;
      zl_in        = zl_ff;
      xi_in        = xi_ff;
      zi_in        = zi_ff;
      u_in         = u_ff;
      v_in         = v_ff;
      acc_in       = acc_ff;
      len2_in      = len2_ff;
      thr_in       = thr_ff;
      score_in     = score_ff;
      best_in      = best_ff;
      rsp_valid_in = rsp_valid_ff;
      out_last_in  = out_last_ff;
      out_in       = out_ff;
      rd_addr      = j_ff;
      stk_we       = 1'b0;
      stk_wa       = top_ff[IW-1:0];
      stk_wd       = '0;
      mul_start    = 1'b0;
      run_in       = run_ff;

      if (mul_done) begin
         run_in = 1'b0;
      end

      case (state_ff)
         S_TOL, S_LEN_A, S_LEN_B, S_THR, S_DOT_A, S_DOT_B, S_SQ_A, S_SQ_B,
         S_SCALE, S_CR_A, S_CR_B, S_CR_SQ: begin
            if (!run_ff) begin
               mul_start = 1'b1;
               run_in    = 1'b1;
            end
         end
         default: begin
            run_in = run_in;
         end
      endcase

      case (state_ff)
         S_LOAD: begin
            if (req_fire) begin
               cnt_in = cnt_ff + 1'b1;
               if (req_in_last || cnt_ff == CNTW'(MAX_POINTS - 1)) begin
                  state_in = S_TOL;
               end
            end
         end
         S_TOL: begin
            if (mul_done) begin
               tol2_in   = mul_p[MW-1:0];
               kf_in     = '0;
               kf_in[0]  = 1'b1;
               kf_in[nl] = 1'b1;
               top_in    = '0;
               if (cnt_ff > CNTW'(2)) begin
                  stk_we = 1'b1;
                  stk_wa = '0;
                  stk_wd = {IW'(0), nl};
                  top_in = CNTW'(1);
               end
               state_in = S_POP;
            end
         end
         S_POP: begin
            if (top_ff == '0) begin
               j_in     = '0;
               state_in = S_OUT_SCAN;
            end else begin
               top_in   = top_ff - 1'b1;
               state_in = S_SEGRD;
            end
         end
         S_SEGRD: begin
            f_in     = stk_rd_ff[2*IW-1:IW];
            l_in     = stk_rd_ff[IW-1:0];
            rd_addr  = stk_rd_ff[2*IW-1:IW];
            state_in = S_RDF;
         end
         S_RDF: begin
            xf_in    = rdx;
            zf_in    = rdz;
            rd_addr  = l_ff;
            state_in = S_RDL;
         end
         S_RDL: begin
            xl_in    = rdx;
            zl_in    = rdz;
            state_in = S_LEN_A;
         end
         S_LEN_A: begin
            if (mul_done) begin
               acc_in   = term;
               state_in = S_LEN_B;
            end
         end
         S_LEN_B: begin
            if (mul_done) begin
               acc_in   = acc_sum;
               len2_in  = acc_sum[LW-1:0];
               state_in = S_THR;
            end
         end
         S_THR: begin
            if (mul_done) begin
               thr_in   = mul_p;
               i_in     = f_ff + 1'b1;
               first_in = 1'b1;
               state_in = S_PTRD;
            end
         end
         S_PTRD: begin
            rd_addr  = i_ff;
            state_in = S_PT;
         end
         S_PT: begin
            xi_in    = rdx;
            zi_in    = rdz;
            state_in = S_DOT_A;
         end
         S_DOT_A: begin
            if (mul_done) begin
               acc_in   = term;
               state_in = S_DOT_B;
            end
         end
         S_DOT_B: begin
            if (mul_done) begin
               acc_in   = acc_sum;
               state_in = S_BR;
            end
         end
         S_BR: begin
            // Projection before the first point or past the last one clamps to that end.
            if (acc_ff[ACCW-1] || acc_ff == '0) begin
               u_in     = dx;
               v_in     = dz;
               state_in = S_SQ_A;
            end else if (acc_ff >= $signed({1'b0, len2_ff})) begin
               u_in     = ex;
               v_in     = ez;
               state_in = S_SQ_A;
            end else begin
               state_in = S_CR_A;
            end
         end
         S_SQ_A, S_CR_A: begin
            if (mul_done) begin
               acc_in   = term;
               state_in = (state_ff == S_SQ_A) ? S_SQ_B : S_CR_B;
            end
         end
         S_SQ_B, S_CR_B: begin
            if (mul_done) begin
               acc_in   = acc_sum;
               state_in = (state_ff == S_SQ_B) ? S_SCALE : S_CR_SQ;
            end
         end
         S_SCALE, S_CR_SQ: begin
            if (mul_done) begin
               score_in = mul_p;
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            if (first_ff || score_ff > best_ff) begin
               best_in    = score_ff;
               best_at_in = i_ff;
            end
            first_in = 1'b0;
            i_in     = i_ff + 1'b1;
            state_in = (IW'(i_ff + 1'b1) == l_ff) ? S_DEC : S_PTRD;
         end
         S_DEC: begin
            if (best_ff > thr_ff) begin
               kf_in[best_at_ff] = 1'b1;
               if (CNTW'(l_ff) > CNTW'(best_at_ff) + 1'b1 &&
                   top_ff < CNTW'(MAX_POINTS)) begin
                  stk_we = 1'b1;
                  stk_wd = {best_at_ff, l_ff};
                  top_in = top_ff + 1'b1;
               end
               state_in = S_PUSH2;
            end else begin
               state_in = S_POP;
            end
         end
         S_PUSH2: begin
            if (CNTW'(best_at_ff) > CNTW'(f_ff) + 1'b1 && top_ff < CNTW'(MAX_POINTS)) begin
               stk_we = 1'b1;
               stk_wd = {f_ff, best_at_ff};
               top_in = top_ff + 1'b1;
            end
            state_in = S_POP;
         end
         S_OUT_SCAN: begin
            if (kf_ff[j_ff]) begin
               rd_addr  = j_ff;
               state_in = S_OUT_RD;
            end else if (j_ff == nl) begin
               cnt_in   = '0;
               state_in = S_LOAD;
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         S_OUT_RD: begin
            out_in       = rd_data_ff;
            out_last_in  = (j_ff == nl);
            rsp_valid_in = 1'b1;
            state_in     = S_OUT_WAIT;
         end
         S_OUT_WAIT: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (j_ff == nl) begin
                  cnt_in   = '0;
                  state_in = S_LOAD;
               end else begin
                  j_in     = j_ff + 1'b1;
                  state_in = S_OUT_SCAN;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         tol_ff       <= TOL_RESET;
         cnt_ff       <= '0;
         top_ff       <= '0;
         kf_ff        <= '0;
         run_ff       <= 1'b0;
         first_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         i_ff         <= '0;
         j_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         top_ff       <= top_in;
         kf_ff        <= kf_in;
         run_ff       <= run_in;
         first_ff     <= first_in;
         rsp_valid_ff <= rsp_valid_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         if (csr_valid && csr_ready) begin
            tol_ff <= csr_tolerance;
         end
      end
   end

   always_ff @(posedge clock) begin
      tol2_ff     <= tol2_in;
      f_ff        <= f_in;
      l_ff        <= l_in;
      best_at_ff  <= best_at_in;
      xf_ff       <= xf_in;
      zf_ff       <= zf_in;
      xl_ff       <= xl_in;
      zl_ff       <= zl_in;
      xi_ff       <= xi_in;
      zi_ff       <= zi_in;
      u_ff        <= u_in;
      v_ff        <= v_in;
      acc_ff      <= acc_in;
      len2_ff     <= len2_in;
      thr_ff      <= thr_in;
      score_ff    <= score_in;
      best_ff     <= best_in;
      out_last_ff <= out_last_in;
      out_ff      <= out_in;
   end

   // Point buffer and segment stack, each with one write and one registered read.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         pt_mem[cnt_ff[IW-1:0]] <= {req_in_x, req_in_y, req_in_z};
      end
      rd_data_ff <= pt_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem[stk_wa] <= stk_wd;
      end
      stk_rd_ff <= stk_mem[stk_ra];
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_x    = out_ff[3*CW-1:2*CW];
   assign rsp_out_y    = out_ff[2*CW-1:CW];
   assign rsp_out_z    = out_ff[CW-1:0];
   assign rsp_out_last = out_last_ff;

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input accepted while a result beat is pending");

   a_stack_bound: assert property (@(posedge clock) disable iff (reset)
      top_ff <= CNTW'(MAX_POINTS))
      else $error("segment stack overflow");

   a_first_kept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> kf_ff[0])
      else $error("first point not marked kept during output");

   a_back_to_load: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_out_last) |=> (req_ready && cnt_ff == '0))
      else $error("block not ready for a new line after the last beat");

endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench for polyline_simplify_rdp: random and directed polylines,
// with an exact Ramer-Douglas-Peucker predictor held in a small scoreboard class.
// Depends on rdp_pkg and the polyline_simplify_rdp RTL.
`timescale 1ns / 1ps

module tb_top;
   import rdp_pkg::*;

   localparam int NPTS = 64;
   localparam int CW = 24;

   typedef logic signed [127:0] wide_type;
   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [CW-1:0] z;
      logic                 last;
   } point_type;

   class rdp_scoreboard;
      logic [TOL_W-1:0]     tol;
      logic signed [CW-1:0] xs[NPTS];
      logic signed [CW-1:0] ys[NPTS];
      logic signed [CW-1:0] zs[NPTS];
      int                   count;
      point_type            kept_q[$];
      int                   mismatches;

      function new();
         tol = TOL_RESET;
         count = 0;
         mismatches = 0;
      endfunction

      // Squared distance of point i to the clamped chord f..l, scaled by len2 unless the chord is degenerate.
      function wide_type chord_dist(int i, int f, int l, wide_type len2);
         wide_type dx, dz, ax, az, dot, ex, ez, crs;
         dx = wide_type'(xs[i]) - wide_type'(xs[f]);
         dz = wide_type'(zs[i]) - wide_type'(zs[f]);
         ax = wide_type'(xs[l]) - wide_type'(xs[f]);
         az = wide_type'(zs[l]) - wide_type'(zs[f]);
         if (len2 == 0) return dx * dx + dz * dz;
         dot = dx * ax + dz * az;
         if (dot <= 0) return (dx * dx + dz * dz) * len2;
         if (dot >= len2) begin
            ex = wide_type'(xs[i]) - wide_type'(xs[l]);
            ez = wide_type'(zs[i]) - wide_type'(zs[l]);
            return (ex * ex + ez * ez) * len2;
         end
         crs = dx * az - dz * ax;
         return crs * crs;
      endfunction

      function void simplify_line(int n);
         logic [NPTS-1:0] keep;
         int seg_f[NPTS];
         int seg_l[NPTS];
         int sp, f, l, best_at, last_at;
         wide_type len2, best, s, thr, tol2, ax, az;
         point_type p;
         keep = '0;
         keep[0] = 1'b1;
         keep[n-1] = 1'b1;
         tol2 = wide_type'(tol) * wide_type'(tol);
         sp = 0;
         if (n - 1 > 1) begin
            seg_f[sp] = 0;
            seg_l[sp] = n - 1;
            sp++;
         end
         while (sp > 0) begin
            sp--;
            f = seg_f[sp];
            l = seg_l[sp];
            ax = wide_type'(xs[l]) - wide_type'(xs[f]);
            az = wide_type'(zs[l]) - wide_type'(zs[f]);
            len2 = ax * ax + az * az;
            best_at = f + 1;
            best = chord_dist(best_at, f, l, len2);
            for (int i = f + 2; i < l; i++) begin
               s = chord_dist(i, f, l, len2);
               if (s > best) begin
                  best = s;
                  best_at = i;
               end
            end
            thr = (len2 == 0) ? tol2 : tol2 * len2;
            if (best > thr) begin
               keep[best_at] = 1'b1;
               if (l > best_at + 1 && sp < NPTS) begin
                  seg_f[sp] = best_at;
                  seg_l[sp] = l;
                  sp++;
               end
               if (best_at > f + 1 && sp < NPTS) begin
                  seg_f[sp] = f;
                  seg_l[sp] = best_at;
                  sp++;
               end
            end
         end
         last_at = 0;
         for (int i = 0; i < n; i++) if (keep[i]) last_at = i;
         for (int i = 0; i < n; i++) begin
            if (keep[i]) begin
               p.x = xs[i];
               p.y = ys[i];
               p.z = zs[i];
               p.last = (i == last_at);
               kept_q.insert(kept_q.size(), p);
            end
         end
      endfunction

      function void note_point(point_type p);
         xs[count] = p.x;
         ys[count] = p.y;
         zs[count] = p.z;
         count++;
         if (p.last || count == NPTS) begin
            simplify_line(count);
            count = 0;
         end
      endfunction

      function void check_beat(point_type got);
         point_type want;
         if (kept_q.size() == 0) begin
            if (mismatches < 10)
               $display("ERROR: unexpected beat x=%0d y=%0d z=%0d last=%0b",
                        got.x, got.y, got.z, got.last);
            mismatches++;
            return;
         end
         want = kept_q.pop_front();
         if (got != want) begin
            if (mismatches < 10)
               $display({"ERROR: beat mismatch exp x=%0d y=%0d z=%0d last=%0b",
                         " got x=%0d y=%0d z=%0d last=%0b"},
                        want.x, want.y, want.z, want.last,
                        got.x, got.y, got.z, got.last);
            mismatches++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [CW-1:0] req_in_x = '0;
   logic signed [CW-1:0] req_in_y = '0;
   logic signed [CW-1:0] req_in_z = '0;
   logic req_in_last = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [CW-1:0] rsp_out_x, rsp_out_y, rsp_out_z;
   logic rsp_out_last;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [TOL_W-1:0] csr_tolerance = '0;

   rdp_scoreboard kept_points = new();
   int gap_pct = 0;
   int stall_pct = 0;

   polyline_simplify_rdp u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_in_x(req_in_x), .req_in_y(req_in_y), .req_in_z(req_in_z),
      .req_in_last(req_in_last),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_out_x(rsp_out_x), .rsp_out_y(rsp_out_y), .rsp_out_z(rsp_out_z),
      .rsp_out_last(rsp_out_last),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_tolerance(csr_tolerance)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #200_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // Result side: take beats and stall at random.
   initial begin
      point_type got;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            got.x = rsp_out_x;
            got.y = rsp_out_y;
            got.z = rsp_out_z;
            got.last = rsp_out_last;
            kept_points.check_beat(got);
         end
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic send_point(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                             logic signed [CW-1:0] z, logic last);
      point_type p;
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_in_x <= x;
      req_in_y <= y;
      req_in_z <= z;
      req_in_last <= last;
      do @(posedge clock); while (!req_ready);
      p.x = x;
      p.y = y;
      p.z = z;
      p.last = last;
      kept_points.note_point(p);
   endtask

   // A spread of zero gives fully random coordinates; otherwise a random walk.
   task automatic send_line(int n, bit close, int spread);
      logic signed [CW-1:0] x, z;
      int r;
      x = CW'($urandom_range(2097151) - 1048576);
      z = CW'($urandom_range(2097151) - 1048576);
      r = 1 << spread;
      for (int k = 0; k < n; k++) begin
         if (spread == 0) begin
            x = CW'($urandom);
            z = CW'($urandom);
         end else begin
            x = CW'(x + ($urandom_range(2 * r) - r));
            z = CW'(z + ($urandom_range(2 * r) - r));
         end
         send_point(x, CW'($urandom), z, close && (k == n - 1));
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (kept_points.kept_q.size() != 0);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_tolerance(logic [TOL_W-1:0] v);
      csr_valid <= 1'b1;
      csr_tolerance <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      kept_points.tol = v;
   endtask

   task automatic random_phase(int items);
      int sent, n, pick;
      sent = 0;
      while (sent < items) begin
         pick = $urandom_range(99);
         if (pick < 3) n = NPTS;
         else if (pick < 15) n = $urandom_range(40, 16);
         else n = $urandom_range(12, 1);
         send_line(n, n < NPTS || $urandom_range(1), (pick % 5 == 0) ? 0 : $urandom_range(20, 4));
         sent += n;
      end
   endtask

   initial begin
      logic [TOL_W-1:0] tols[4];
      int modes_gap[4], modes_stall[4];
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed lines at the reset tolerance of 256.
      send_point(24'sd100, 24'sd5, 24'sd200, 1'b1);
      send_point(-24'sd8388608, 24'sd8388607, 24'sd8388607, 1'b0);
      send_point(24'sd8388607, -24'sd8388608, -24'sd8388608, 1'b1);
      // Collinear middle point sits on the chord and is dropped.
      send_point(24'sd0, 24'sd1, 24'sd0, 1'b0);
      send_point(24'sd1000, 24'sd2, 24'sd1000, 1'b0);
      send_point(24'sd2000, 24'sd3, 24'sd2000, 1'b1);
      // Far middle point is kept, and the two extremes span the full range.
      send_point(-24'sd8388608, 24'sd0, -24'sd8388608, 1'b0);
      send_point(24'sd8388607, 24'sd0, -24'sd8388608, 1'b0);
      send_point(24'sd8388607, 24'sd0, 24'sd8388607, 1'b1);
      // Closed loop: first and last coincide in XZ.
      send_point(24'sd500, 24'sd0, 24'sd500, 1'b0);
      send_point(24'sd900, 24'sd7, 24'sd500, 1'b0);
      send_point(24'sd900, 24'sd8, 24'sd900, 1'b0);
      send_point(24'sd500, 24'sd9, 24'sd500, 1'b1);
      // Two interior points at equal distance: the earlier one wins.
      send_point(24'sd0, 24'sd0, 24'sd0, 1'b0);
      send_point(24'sd100, 24'sd0, 24'sd600, 1'b0);
      send_point(24'sd200, 24'sd0, 24'sd600, 1'b0);
      send_point(24'sd300, 24'sd0, 24'sd0, 1'b1);
      // Points just inside and just beyond the chord end.
      send_point(24'sd0, 24'sd0, 24'sd0, 1'b0);
      send_point(-24'sd257, 24'sd0, 24'sd0, 1'b0);
      send_point(24'sd256, 24'sd0, 24'sd0, 1'b0);
      send_point(24'sd1257, 24'sd0, 24'sd0, 1'b0);
      send_point(24'sd1000, 24'sd0, 24'sd0, 1'b1);
      wait_drained();

      tols[0] = 23'd0;
      tols[1] = 23'h7FFFFF;
      tols[2] = TOL_W'($urandom_range(4096, 1));
      tols[3] = TOL_W'($urandom);
      modes_gap = '{0, 80, 0, 22};
      modes_stall = '{0, 0, 80, 22};
      for (int ph = 0; ph < 4; ph++) begin
         write_tolerance(tols[ph]);
         gap_pct = modes_gap[ph];
         stall_pct = modes_stall[ph];
         if (ph == 0) send_line(NPTS, 1'b0, 12);
         random_phase(32);
         wait_drained();
         random_phase(32);
         wait_drained();
      end

      if (kept_points.mismatches == 0 && kept_points.kept_q.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
